>>> rtl/core/mdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared types and constants for the RV32M multiply/divide unit.
// ----------------------------------------------------------------------------
package mdu_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned CMD_WIDTH = 3;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [CMD_WIDTH-1:0] CMD_MUL    = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_MULH   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MULHSU = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_MULHU  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV    = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_DIVU   = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_REM    = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_REMU   = 3'd7;

   // classified operation passed from front to back
   typedef struct packed {
      logic              is_div;     // divide/remainder, else multiply
      logic              want_high;  // high product word / remainder
      logic              neg_result; // negate the unsigned result
      logic              special;    // result known up front
      logic [XLEN-1:0]   special_val;
      logic [XLEN-1:0]   mag_a;      // operand magnitudes / raw values
      logic [XLEN-1:0]   mag_b;
      logic              sign_a;     // for signed multiply correction
      logic              sign_b;
   } op_type;

endpackage
`default_nettype wire

>>> rtl/core/mdu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_front
// Decodes the command and prepares operands: magnitudes, result sign and
// the special divide cases, registered into one op record.
// ----------------------------------------------------------------------------
module mdu_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [mdu_pkg::CMD_WIDTH-1:0] command,
   input  wire logic [mdu_pkg::XLEN-1:0]     left_operand,
   input  wire logic [mdu_pkg::XLEN-1:0]     right_operand,
   output mdu_pkg::op_type                   op_out,
   output logic                              op_valid
);
   import mdu_pkg::*;

   op_type op_in, op_ff;
   logic   valid_ff;
   logic   sa, sb, signed_a, signed_b, b_zero, ovf;
   logic [XLEN-1:0] min_val;

   always_comb begin
      min_val  = {1'b1, {(XLEN-1){1'b0}}};
      signed_a = (command == CMD_MULH) || (command == CMD_MULHSU) ||
                 (command == CMD_DIV)  || (command == CMD_REM);
      signed_b = (command == CMD_MULH) || (command == CMD_DIV) ||
                 (command == CMD_REM);
      sa       = signed_a & left_operand[XLEN-1];
      sb       = signed_b & right_operand[XLEN-1];
      b_zero   = (right_operand == '0);
      ovf      = (left_operand == min_val) && (&right_operand);
      op_in    = '0;
      op_in.is_div    = command[2];
      op_in.want_high = command[2] ? command[1] : (command != CMD_MUL);
      op_in.sign_a    = sa;
      op_in.sign_b    = sb;
      if (command[2]) begin
         // divider works on magnitudes
         op_in.mag_a = sa ? (~left_operand + 1'b1) : left_operand;
         op_in.mag_b = sb ? (~right_operand + 1'b1) : right_operand;
         op_in.neg_result = command[1] ? sa : (sa ^ sb);
      end else begin
         op_in.mag_a = left_operand;
         op_in.mag_b = right_operand;
      end
      if (command[2] && b_zero) begin
         op_in.special     = 1'b1;
         op_in.special_val = command[1] ? left_operand : '1;
      end else if (command[2] && !command[0] && ovf) begin
         op_in.special     = 1'b1;
         op_in.special_val = command[1] ? '0 : min_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      op_ff <= op_in;
   end

   assign op_out   = op_ff;
   assign op_valid = valid_ff;

endmodule
`default_nettype wire

>>> rtl/core/mdu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_queue
// Small fifo between the decode front and the execute back end.
// ----------------------------------------------------------------------------
module mdu_queue #(
   parameter int unsigned DEPTH = mdu_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mdu_pkg::op_type       push_data,
   input  wire logic             pop,
   output mdu_pkg::op_type       pop_data,
   output logic                  not_empty,
   output logic                  almost_full
);
   import mdu_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   op_type            mem [DEPTH];
   logic [AW-1:0]     wr_ff, rd_ff;
   logic [AW:0]       cnt_ff;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= bump(wr_ff);
         if (pop)  rd_ff <= bump(rd_ff);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem[wr_ff] <= push_data;
   end

   assign pop_data    = mem[rd_ff];
   assign not_empty   = (cnt_ff != '0);
   // two slots held back for the item in the front register and the one arriving
   assign almost_full = (cnt_ff >= (AW+1)'(DEPTH - 2));

   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && cnt_ff == (AW+1)'(DEPTH)))
      else $error("queue pushed while full");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH))
      else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/core/mdu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_back
// Execute side: a two-stage pipelined multiplier and a radix-2 iterative
// divider over magnitudes. Multiplies flow one per cycle while the divider is
// idle; a divide holds the unit until its last quotient bit is formed.
// ----------------------------------------------------------------------------
module mdu_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     op_avail,
   input  mdu_pkg::op_type               op_in,
   output logic                          op_take,
   output logic                          rsp_strobe,
   output logic [mdu_pkg::XLEN-1:0]      rsp_result_word
);
   import mdu_pkg::*;

   localparam int unsigned HW = XLEN / 2;
   localparam int unsigned CW = $clog2(XLEN + 1);

   // ---------------- multiplier: 16x16 partial products then sum
   logic            m1_v_ff, m2_v_ff;
   logic            m1_hi_ff;
   logic [XLEN-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [XLEN-1:0] corr_ff, m_a, m_b, corr_in;
   logic [2*XLEN-1:0] prod;
   logic [XLEN-1:0] m2_res_ff;

   // ---------------- divider
   logic            d_busy_ff, d_done_ff, d_neg_ff;
   logic [CW-1:0]   d_cnt_ff;
   logic [XLEN-1:0] d_quo_ff, d_rem_ff, d_div_ff, d_res;
   logic            d_high_ff;
   logic [XLEN+1:0] d_trial;
   logic [XLEN:0]   d_rem_sh;
   logic            s_v_ff, s2_v_ff;
   logic [XLEN-1:0] s_val_ff, s2_val_ff;

   logic take_mul, take_div, take_spec;

   always_comb begin
      take_spec = op_avail && op_in.special && !d_busy_ff;
      take_div  = op_avail && op_in.is_div && !op_in.special && !d_busy_ff;
      take_mul  = op_avail && !op_in.is_div && !d_busy_ff;
      op_take   = take_spec || take_div || take_mul;
      m_a = op_in.mag_a;
      m_b = op_in.mag_b;
      // signed high-word correction: subtract b<<32 when a<0, a<<32 when b<0
      corr_in = (op_in.sign_a ? m_b : '0) + (op_in.sign_b ? m_a : '0);
      prod = {pp_hh_ff, pp_ll_ff}
           + {{HW{1'b0}}, pp_lh_ff, {HW{1'b0}}}
           + {{HW{1'b0}}, pp_hl_ff, {HW{1'b0}}};
      d_rem_sh = {d_rem_ff, d_quo_ff[XLEN-1]};
      d_trial  = {1'b0, d_rem_sh} - {2'b00, d_div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff   <= 1'b0;
         m2_v_ff   <= 1'b0;
         d_busy_ff <= 1'b0;
         d_done_ff <= 1'b0;
         s_v_ff    <= 1'b0;
         s2_v_ff   <= 1'b0;
         d_cnt_ff  <= '0;
      end else begin
         m1_v_ff <= take_mul;
         m2_v_ff <= m1_v_ff;
         s_v_ff  <= take_spec;
         s2_v_ff <= s_v_ff;
         d_done_ff <= 1'b0;
         if (take_div) begin
            d_busy_ff <= 1'b1;
            d_cnt_ff  <= CW'(XLEN);
         end else if (d_busy_ff) begin
            d_cnt_ff <= d_cnt_ff - 1'b1;
            if (d_cnt_ff == CW'(1)) begin
               d_busy_ff <= 1'b0;
               d_done_ff <= 1'b1;
            end
         end
      end
      // multiplier datapath
      pp_ll_ff <= XLEN'(m_a[HW-1:0])    * XLEN'(m_b[HW-1:0]);
      pp_lh_ff <= XLEN'(m_a[HW-1:0])    * XLEN'(m_b[XLEN-1:HW]);
      pp_hl_ff <= XLEN'(m_a[XLEN-1:HW]) * XLEN'(m_b[HW-1:0]);
      pp_hh_ff <= XLEN'(m_a[XLEN-1:HW]) * XLEN'(m_b[XLEN-1:HW]);
      corr_ff  <= corr_in;
      m1_hi_ff <= op_in.want_high;
      m2_res_ff <= m1_hi_ff ? (prod[2*XLEN-1:XLEN] - corr_ff) : prod[XLEN-1:0];
      // known results ride two stages to line up with the multiplier
      s_val_ff  <= op_in.special_val;
      s2_val_ff <= s_val_ff;
      // divider datapath, restoring, one quotient bit a cycle
      if (take_div) begin
         d_quo_ff  <= op_in.mag_a;
         d_rem_ff  <= '0;
         d_div_ff  <= op_in.mag_b;
         d_neg_ff  <= op_in.neg_result;
         d_high_ff <= op_in.want_high;
      end else if (d_busy_ff) begin
         d_quo_ff <= {d_quo_ff[XLEN-2:0], !d_trial[XLEN+1]};
         d_rem_ff <= d_trial[XLEN+1] ? d_rem_sh[XLEN-1:0] : d_trial[XLEN-1:0];
      end
   end

   always_comb begin
      d_res = d_high_ff ? d_rem_ff : d_quo_ff;
      if (d_neg_ff) d_res = ~d_res + 1'b1;
   end

   // at most one source finishes a cycle: issue is serialized by the single take
   always_comb begin
      rsp_strobe = m2_v_ff || d_done_ff || s2_v_ff;
      priority if (m2_v_ff) begin
         rsp_result_word = m2_res_ff;
      end else if (d_done_ff) begin
         rsp_result_word = d_res;
      end else begin
         rsp_result_word = s2_val_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      $countones({m2_v_ff, d_done_ff, s2_v_ff}) <= 1)
      else $error("two results in one cycle");
   assert property (@(posedge clock) disable iff (reset) d_busy_ff |-> !op_take)
      else $error("issue while divider busy");
   assert property (@(posedge clock) disable iff (reset)
      (d_busy_ff && d_cnt_ff == CW'(1)) |=> d_done_ff)
      else $error("divide did not finish");

endmodule
`default_nettype wire

>>> rtl/core/rv32m_multiply_divide_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_unit_top
// RV32M multiply/divide unit with decode front, op queue and execute back.
// ----------------------------------------------------------------------------
// path: the front registers each accepted command into the op queue; from
// there multiplies pass stages m1 and m2, divide by zero and signed overflow
// pass s and s2, and a divide holds the radix-2 divider while it forms one
// quotient bit per cycle; multiplies issue one per cycle while it is idle
// busy rises when the op queue nears full; the receiver cannot stall
// reset is synchronous, clears queue, valid bits and divider control
module rv32m_multiply_divide_unit_top #(
   parameter int unsigned QDEPTH = mdu_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mdu_pkg::CMD_WIDTH-1:0] req_command,
   input  wire logic [mdu_pkg::XLEN-1:0]      req_left_operand,
   input  wire logic [mdu_pkg::XLEN-1:0]      req_right_operand,
   output logic                               rsp_strobe,
   output logic [mdu_pkg::XLEN-1:0]           rsp_result_word
);
   import mdu_pkg::*;

   op_type f_op, q_op;
   logic   f_valid, q_avail, q_take, q_afull, accept;

   assign busy   = q_afull;
   assign accept = start && !busy;

   mdu_front u_front (
      .clock, .reset,
      .in_valid      (accept),
      .command       (req_command),
      .left_operand  (req_left_operand),
      .right_operand (req_right_operand),
      .op_out        (f_op),
      .op_valid      (f_valid)
   );

   mdu_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset,
      .push        (f_valid),
      .push_data   (f_op),
      .pop         (q_take),
      .pop_data    (q_op),
      .not_empty   (q_avail),
      .almost_full (q_afull)
   );

   mdu_back u_back (
      .clock, .reset,
      .op_avail        (q_avail),
      .op_in           (q_op),
      .op_take         (q_take),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_word (rsp_result_word)
   );

endmodule
`default_nettype wire

>>> tb/sv/rv32m_mdu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32m_mdu_checker
// Watches the command and result channels of the RV32M multiply/divide unit,
// computes the expected destination word of each accepted command and
// compares results in order.
// ----------------------------------------------------------------------------
module rv32m_mdu_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [mdu_pkg::CMD_WIDTH-1:0] req_command,
   input  wire logic [mdu_pkg::XLEN-1:0]      req_left_operand,
   input  wire logic [mdu_pkg::XLEN-1:0]      req_right_operand,
   input  wire logic                          rsp_strobe,
   input  wire logic [mdu_pkg::XLEN-1:0]      rsp_result_word,
   output int                                 fail_count,
   output int                                 pending_words,
   output int                                 results_seen
);
   import mdu_pkg::*;

   logic [XLEN-1:0] expected_words[$];

   function automatic logic [XLEN-1:0] abs_word(input logic [XLEN-1:0] w);
      return w[XLEN-1] ? (~w + 1'b1) : w;
   endfunction

   function automatic logic [XLEN-1:0] rv32m_result(input logic [CMD_WIDTH-1:0] cmd,
                                                  input logic [XLEN-1:0] a,
                                                  input logic [XLEN-1:0] b);
      logic [63:0] wa_s, wb_s, wa_u, wb_u, prod;
      logic [XLEN-1:0] q, r;
      wa_s = {{32{a[31]}}, a};
      wb_s = {{32{b[31]}}, b};
      wa_u = {32'd0, a};
      wb_u = {32'd0, b};
      case (cmd)
         CMD_MUL: begin
            prod = wa_u * wb_u;
            return prod[31:0];
         end
         CMD_MULH: begin
            prod = wa_s * wb_s;
            return prod[63:32];
         end
         CMD_MULHSU: begin
            prod = wa_s * wb_u;
            return prod[63:32];
         end
         CMD_MULHU: begin
            prod = wa_u * wb_u;
            return prod[63:32];
         end
         CMD_DIV, CMD_REM: begin
            if (b == 0) return (cmd == CMD_DIV) ? 32'hFFFF_FFFF : a;
            // signed overflow
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
               return (cmd == CMD_DIV) ? 32'h8000_0000 : 32'd0;
            q = abs_word(a) / abs_word(b);
            r = abs_word(a) % abs_word(b);
            if (cmd == CMD_DIV) return (a[31] ^ b[31]) ? (~q + 1'b1) : q;
            return a[31] ? (~r + 1'b1) : r;
         end
         CMD_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
         default: return (b == 0) ? a : a % b;
      endcase
   endfunction

   assign pending_words = expected_words.size();

   always @(posedge clock) begin
      logic [XLEN-1:0] exp_word;
      if (reset) begin
         expected_words.delete();
         fail_count <= 0;
         results_seen <= 0;
      end else begin
         // response is checked before the new transaction is queued
         if (rsp_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("mismatch: unexpected result %h", rsp_result_word);
               fail_count <= fail_count + 1;
            end else begin
               exp_word = expected_words.pop_front();
               if (exp_word !== rsp_result_word) begin
                  if (fail_count < 10)
                     $display("mismatch: result_word expected %h actual %h",
                              exp_word, rsp_result_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_words.push_back(rv32m_result(req_command, req_left_operand,
                                                  req_right_operand));
      end
   end
endmodule

>>> tb/sv/tb_rv32m_multiply_divide_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32m_multiply_divide_unit_top
// Drives directed and random RV32M commands with random gaps into the unit;
// the checker predicts each destination word and reports the verdict count.
// ----------------------------------------------------------------------------
module tb_rv32m_multiply_divide_unit_top;
   import mdu_pkg::*;

   logic clock, reset, start, busy, rsp_strobe;
   logic [CMD_WIDTH-1:0] req_command;
   logic [XLEN-1:0] req_left_operand, req_right_operand, rsp_result_word;
   int fail_count, pending_words, results_seen;
   int sent_count;

   rv32m_multiply_divide_unit_top DUT (
      .clock, .reset, .start, .busy, .req_command, .req_left_operand,
      .req_right_operand, .rsp_strobe, .rsp_result_word
   );

   rv32m_mdu_checker checker_i (
      .clock, .reset, .start, .busy, .req_command, .req_left_operand,
      .req_right_operand, .rsp_strobe, .rsp_result_word, .fail_count,
      .pending_words, .results_seen
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [XLEN-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 15);
         5: return -$urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   // hold one transaction until accepted
   task automatic issue_command(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                input bit allow_gap);
      if (allow_gap) begin
         while ($urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_command <= cmd;
      req_left_operand <= a;
      req_right_operand <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   initial begin
      logic [XLEN-1:0] edge_vals[6];
      edge_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd7};
      start = 0;
      req_command = CMD_MUL;
      req_left_operand = 0;
      req_right_operand = 0;
      sent_count = 0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int c = 0; c < 8; c++) begin
         issue_command(c[2:0], 32'h8000_0000, 32'hFFFF_FFFF, 0);
         issue_command(c[2:0], 32'h1234_5678, 32'd0, 0);
      end
      for (int i = 0; i < 8; i++)
         issue_command(i[2:0], edge_vals[i % 6], edge_vals[(i + 2) % 6], 0);

      // drain before random traffic
      start <= 1'b0;
      while (pending_words != 0) @(negedge clock);

      for (int n = 0; n < 700; n++)
         issue_command(CMD_WIDTH'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                       (n < 200 || n >= 350));
      start <= 1'b0;

      while (pending_words != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("sent %0d commands over all eight operations, %0d results checked",
               sent_count, results_seen);
      if (fail_count == 0 && pending_words == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
